FILE: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// shared constants and types of the serial frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int FRAME_MAX    = 64;
    localparam int IDX_W        = $clog2(FRAME_MAX);
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 16;
    localparam int CNT_W        = 6;
    localparam int HEADER_EXTRA = 3;
    localparam int STOP_OFFSET  = 2;
    localparam int PAYLOAD_BASE = 5;

    // header positions within the frame store
    localparam logic [IDX_W-1:0] POS_LENGTH  = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_TYPE    = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_ADDR_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_ADDR_HI = IDX_W'(4);

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_START = 1'b0;
    localparam logic REG_STOP  = 1'b1;
    localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h55;

    // frame handed from the parser to the drain
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] ftype;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } frame_desc_t;

endpackage

FILE: rtl/sfp_frame_ram.sv
// ----------------------------------------------------------------------------
// sfp_frame_ram
// frame store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sfp_frame_ram (
    input  logic                             clk,
    input  logic                             we,
    input  logic [sfp_pkg::IDX_W-1:0]        waddr,
    input  logic [sfp_pkg::BYTE_W-1:0]       wdata,
    input  logic                             re,
    input  logic [sfp_pkg::IDX_W-1:0]        raddr,
    output logic [sfp_pkg::BYTE_W-1:0]       rdata
);

    logic [sfp_pkg::BYTE_W-1:0] mem [sfp_pkg::FRAME_MAX];
    logic [sfp_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sfp_parser.sv
// ----------------------------------------------------------------------------
// sfp_parser
// byte index tracking, store writes, header capture and stop check
// ----------------------------------------------------------------------------
module sfp_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [sfp_pkg::BYTE_W-1:0]        rx_byte,
    input  logic [sfp_pkg::BYTE_W-1:0]        start_byte,
    input  logic [sfp_pkg::BYTE_W-1:0]        stop_byte,
    output logic                              we,
    output logic [sfp_pkg::IDX_W-1:0]         waddr,
    output logic [sfp_pkg::BYTE_W-1:0]        wdata,
    output logic [sfp_pkg::IDX_W-1:0]         idx,
    output sfp_pkg::frame_desc_t              desc
);

    logic [sfp_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [sfp_pkg::BYTE_W-1:0] length_reg, length_next;
    logic [sfp_pkg::BYTE_W-1:0] type_reg;
    logic [sfp_pkg::BYTE_W-1:0] addr_lo_reg;
    logic [sfp_pkg::BYTE_W-1:0] addr_hi_reg;
    logic                       at_stop;
    logic                       good_stop;

    // stop position is length+2, compared one bit wider than the length
    assign at_stop = (idx_reg >= sfp_pkg::IDX_W'(sfp_pkg::STOP_OFFSET)) &&
                     ((sfp_pkg::BYTE_W+1)'(idx_reg) ==
                      (sfp_pkg::BYTE_W+1)'(length_reg) +
                      (sfp_pkg::BYTE_W+1)'(sfp_pkg::STOP_OFFSET));
    assign good_stop = at_stop && (rx_byte == stop_byte) &&
                       (length_reg >= sfp_pkg::BYTE_W'(sfp_pkg::HEADER_EXTRA));

    always_comb
    begin
        idx_next    = idx_reg;
        length_next = length_reg;
        if (accept)
        begin
            if (idx_reg == sfp_pkg::POS_LENGTH)
            begin
                length_next = rx_byte;
            end
            if (at_stop)
            begin
                idx_next = '0;
            end
            else if (idx_reg == '0)
            begin
                if (rx_byte == start_byte)
                begin
                    idx_next = sfp_pkg::POS_LENGTH;
                end
            end
            else if (idx_reg == sfp_pkg::IDX_W'(sfp_pkg::FRAME_MAX - 1))
            begin
                // store overrun
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            length_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            length_reg <= length_next;
        end
    end

    // header bytes kept beside the store for the drain
    always_ff @(posedge clk)
    begin
        if (accept && (idx_reg == sfp_pkg::POS_TYPE))
        begin
            type_reg <= rx_byte;
        end
        if (accept && (idx_reg == sfp_pkg::POS_ADDR_LO))
        begin
            addr_lo_reg <= rx_byte;
        end
        if (accept && (idx_reg == sfp_pkg::POS_ADDR_HI))
        begin
            addr_hi_reg <= rx_byte;
        end
    end

    assign we    = accept;
    assign waddr = idx_reg;
    assign wdata = rx_byte;
    assign idx   = idx_reg;

    assign desc.valid = accept && good_stop;
    assign desc.ftype = type_reg;
    assign desc.addr  = {addr_hi_reg, addr_lo_reg};
    assign desc.count = sfp_pkg::CNT_W'(length_reg -
                                        sfp_pkg::BYTE_W'(sfp_pkg::HEADER_EXTRA));

endmodule

FILE: rtl/sfp_drain.sv
// ----------------------------------------------------------------------------
// sfp_drain
// reads the payload back from the store and fills the result register
// ----------------------------------------------------------------------------
module sfp_drain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfp_pkg::frame_desc_t              desc,
    output logic                              idle,
    output logic                              re,
    output logic [sfp_pkg::IDX_W-1:0]         raddr,
    input  logic [sfp_pkg::BYTE_W-1:0]        rdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sfp_pkg::BYTE_W-1:0]        frame_type,
    output logic [sfp_pkg::ADDR_W-1:0]        frame_addr,
    output logic [sfp_pkg::CNT_W-1:0]         payload_count,
    output logic [sfp_pkg::BYTE_W-1:0]        data_byte,
    output logic                              data_valid,
    output logic                              last
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_READ,
        D_LOAD,
        D_EMPTY
    } drain_state_t;

    drain_state_t               state_reg, state_next;
    logic [sfp_pkg::BYTE_W-1:0] type_reg, type_next;
    logic [sfp_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [sfp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sfp_pkg::CNT_W-1:0]  k_reg, k_next;
    logic                       ov_reg, ov_next;
    logic [sfp_pkg::BYTE_W-1:0] ot_reg, ot_next;
    logic [sfp_pkg::ADDR_W-1:0] oa_reg, oa_next;
    logic [sfp_pkg::CNT_W-1:0]  oc_reg, oc_next;
    logic [sfp_pkg::BYTE_W-1:0] db_reg, db_next;
    logic                       dv_reg, dv_next;
    logic                       last_reg, last_next;
    logic                       slot_free;
    logic                       final_byte;

    assign slot_free  = !ov_reg || out_ready;
    assign final_byte = (k_reg == cnt_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        type_next  = type_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !out_ready;
        ot_next    = ot_reg;
        oa_next    = oa_reg;
        oc_next    = oc_reg;
        db_next    = db_reg;
        dv_next    = dv_reg;
        last_next  = last_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (desc.valid)
                begin
                    type_next  = desc.ftype;
                    addr_next  = desc.addr;
                    cnt_next   = desc.count;
                    k_next     = '0;
                    state_next = (desc.count == '0) ? D_EMPTY : D_READ;
                end
            end
            D_READ:
            begin
                state_next = D_LOAD;
            end
            D_LOAD:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ot_next    = type_reg;
                    oa_next    = addr_reg;
                    oc_next    = cnt_reg;
                    db_next    = rdata;
                    dv_next    = 1'b1;
                    last_next  = final_byte;
                    k_next     = k_reg + 1'b1;
                    state_next = final_byte ? D_IDLE : D_READ;
                end
            end
            D_EMPTY:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ot_next    = type_reg;
                    oa_next    = addr_reg;
                    oc_next    = '0;
                    db_next    = '0;
                    dv_next    = 1'b0;
                    last_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            type_reg  <= '0;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            ot_reg    <= '0;
            oa_reg    <= '0;
            oc_reg    <= '0;
            db_reg    <= '0;
            dv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            type_reg  <= type_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            ot_reg    <= ot_next;
            oa_reg    <= oa_next;
            oc_reg    <= oc_next;
            db_reg    <= db_next;
            dv_reg    <= dv_next;
            last_reg  <= last_next;
        end
    end

    assign idle  = (state_reg == D_IDLE);
    assign re    = (state_reg == D_READ);
    assign raddr = sfp_pkg::IDX_W'(sfp_pkg::PAYLOAD_BASE) + sfp_pkg::IDX_W'(k_reg);

    // result fields: own copy of the header, so a waiting result survives
    // the next frame being parsed
    assign out_valid     = ov_reg;
    assign frame_type    = ot_reg;
    assign frame_addr    = oa_reg;
    assign payload_count = oc_reg;
    assign data_byte     = db_reg;
    assign data_valid    = dv_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/serial_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_unit
// start/length/stop byte frame parser with a frame store and result drain
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready, rx_byte): one received byte per request.
//   the parser hunts for start_byte, stores length, type, address (low byte
//   first) and payload, and checks the byte at index length+2 against
//   stop_byte. a good frame is returned on the output channel (out_valid/
//   out_ready) as one request per payload byte, last set on the final one;
//   an empty payload gives one request with data_valid low.
//   ordinary bytes are taken while the drain is idle. after a good stop the
//   drain reads the payload back from the frame store, reading and then
//   loading each result in turn, and holds off the input until the final
//   result is loaded. an empty payload goes through a state of its own, which
//   holds off the input until its result is loaded into the result register.
//   in_ready stays high while the last result of a frame still waits in the
//   result register, which keeps its own copy of the header; while a frame
//   drains, a stalled receiver stalls the drain and keeps in_ready low.
//   reset clears the byte index, the length and the result register and
//   loads start_byte 0xaa, stop_byte 0x55; the store needs no clearing.
//   configuration through the apb port: start_byte at 0x0, stop_byte at 0x4.
// ----------------------------------------------------------------------------
module serial_frame_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sfp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sfp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // received bytes
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]          rx_byte,
    // results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfp_pkg::BYTE_W-1:0]          frame_type,
    output logic [sfp_pkg::ADDR_W-1:0]          frame_addr,
    output logic [sfp_pkg::CNT_W-1:0]           payload_count,
    output logic [sfp_pkg::BYTE_W-1:0]          data_byte,
    output logic                                data_valid,
    output logic                                last
);

    logic [sfp_pkg::BYTE_W-1:0] start_reg;
    logic [sfp_pkg::BYTE_W-1:0] stop_reg;
    logic                       cfg_wr;
    logic                       accept;
    logic                       drain_idle;
    logic                       we;
    logic [sfp_pkg::IDX_W-1:0]  waddr;
    logic [sfp_pkg::BYTE_W-1:0] wdata;
    logic                       re;
    logic [sfp_pkg::IDX_W-1:0]  raddr;
    logic [sfp_pkg::BYTE_W-1:0] rdata;
    logic [sfp_pkg::IDX_W-1:0]  idx;
    sfp_pkg::frame_desc_t       desc;

    // register file, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= sfp_pkg::START_RESET;
            stop_reg  <= sfp_pkg::STOP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                sfp_pkg::REG_START: start_reg <= pwdata[sfp_pkg::BYTE_W-1:0];
                sfp_pkg::REG_STOP:  stop_reg  <= pwdata[sfp_pkg::BYTE_W-1:0];
                default:            start_reg <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sfp_pkg::REG_START: prdata = sfp_pkg::APB_DATA_W'(start_reg);
            sfp_pkg::REG_STOP:  prdata = sfp_pkg::APB_DATA_W'(stop_reg);
            default:            prdata = '0;
        endcase
    end

    // bytes flow only while no frame is draining
    assign in_ready = drain_idle;
    assign accept   = in_valid && in_ready;

    sfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .start_byte (start_reg),
        .stop_byte  (stop_reg),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .idx        (idx),
        .desc       (desc)
    );

    sfp_frame_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    sfp_drain u_drain (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc          (desc),
        .idle          (drain_idle),
        .re            (re),
        .raddr         (raddr),
        .rdata         (rdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_type    (frame_type),
        .frame_addr    (frame_addr),
        .payload_count (payload_count),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .last          (last)
    );

    // a good stop only ever lands at or past the first payload position
    a_stop_position: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid |-> (idx >= sfp_pkg::IDX_W'(sfp_pkg::PAYLOAD_BASE)))
        else $error("frame launched before the payload position");

    // the store is never written while its payload is read back
    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid |=> !in_ready)
        else $error("input taken while a frame drains");

    // a payload result always belongs to a non-empty frame
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |-> (payload_count != '0))
        else $error("payload result with zero count");

endmodule

FILE: sim/serial_frame_parser_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_parser_checker
// watches the byte and result channels of the frame parser, predicts every
// frame it should return and compares each returned result field by field
// ----------------------------------------------------------------------------
module serial_frame_parser_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sfp_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]          rx_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]          frame_type,
    input  logic [sfp_pkg::ADDR_W-1:0]          frame_addr,
    input  logic [sfp_pkg::CNT_W-1:0]           payload_count,
    input  logic [sfp_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                data_valid,
    input  logic                                last,
    output int                                  mismatches,
    output int                                  results_due
);

    import sfp_pkg::*;

    // register index times four
    localparam logic [APB_ADDR_W-1:0] START_ADDR = {REG_START, 2'b00};
    localparam logic [APB_ADDR_W-1:0] STOP_ADDR  = {REG_STOP, 2'b00};

    typedef struct packed {
        logic [BYTE_W-1:0] ftype;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] data;
        logic              dvalid;
        logic              last;
    } frame_result_t;

    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
    logic [IDX_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] byte_store [FRAME_MAX];
    frame_result_t     frame_results_due [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] frame result mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one received byte through the parser
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        int            cnt;
        frame_result_t r;
        byte_store[byte_pos] = b;
        if (byte_pos == POS_LENGTH)
            frame_len = b;
        if (byte_pos >= STOP_OFFSET && int'(byte_pos) == int'(frame_len) + STOP_OFFSET) begin
            // short lengths are dropped whatever the closing byte
            if (b == stop_code && frame_len >= HEADER_EXTRA) begin
                cnt     = int'(frame_len) - HEADER_EXTRA;
                r.ftype = byte_store[POS_TYPE];
                r.addr  = {byte_store[POS_ADDR_HI], byte_store[POS_ADDR_LO]};
                if (cnt == 0) begin
                    r.count  = '0;
                    r.data   = '0;
                    r.dvalid = 1'b0;
                    r.last   = 1'b1;
                    frame_results_due.push_back(r);
                end
                else begin
                    for (int k = 0; k < cnt; k++) begin
                        r.count  = CNT_W'(cnt);
                        r.data   = byte_store[PAYLOAD_BASE + k];
                        r.dvalid = 1'b1;
                        r.last   = (k == cnt - 1);
                        frame_results_due.push_back(r);
                    end
                end
            end
            // closing byte is never looked at again as a start
            byte_pos = '0;
        end
        else if (byte_pos == '0) begin
            if (b == start_code)
                byte_pos = POS_LENGTH;
        end
        else if (int'(byte_pos) == FRAME_MAX - 1) begin
            byte_pos = '0;
        end
        else begin
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("result with none expected, type %02h addr %04h",
                frame_type, frame_addr));
        end
        else begin
            want = frame_results_due.pop_front();
            if (frame_type !== want.ftype)
                report_mismatch($sformatf("frame_type %02h, want %02h", frame_type, want.ftype));
            if (frame_addr !== want.addr)
                report_mismatch($sformatf("frame_addr %04h, want %04h", frame_addr, want.addr));
            if (payload_count !== want.count)
                report_mismatch($sformatf("payload_count %0d, want %0d",
                    payload_count, want.count));
            if (data_byte !== want.data)
                report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
            if (data_valid !== want.dvalid)
                report_mismatch($sformatf("data_valid %b, want %b", data_valid, want.dvalid));
            if (last !== want.last)
                report_mismatch($sformatf("last %b, want %b", last, want.last));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            start_code  = START_RESET;
            stop_code   = STOP_RESET;
            byte_pos    = '0;
            frame_len   = '0;
            mismatches  = 0;
            frame_results_due.delete();
        end
        else begin
            if (in_valid && in_ready)
                parse_byte(rx_byte);
            if (out_valid && out_ready)
                check_result();
            if (psel && penable && pwrite && pready) begin
                if (paddr == START_ADDR)
                    start_code = pwdata[BYTE_W-1:0];
                else if (paddr == STOP_ADDR)
                    stop_code = pwdata[BYTE_W-1:0];
            end
        end
        results_due = frame_results_due.size();
    end

endmodule

FILE: sim/serial_frame_parser_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_parser_unit_test
// drives byte streams and start/stop settings into the frame parser
// ----------------------------------------------------------------------------
// a short directed stream covers the header extremes, an empty payload, a
// bad stop that equals the start byte and a short length; random streams of
// mostly well-formed frames mixed with broken frames, overruns and line
// noise follow under several start/stop settings. a side checker predicts
// and compares every result; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module serial_frame_parser_unit_test;

    import sfp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int GAP_MAX      = 18;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int SETTLE       = 8;     // idle cycles after the last result
    localparam int PHASE_BYTES  = 22;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [APB_ADDR_W-1:0] START_ADDR = {REG_START, 2'b00};
    localparam logic [APB_ADDR_W-1:0] STOP_ADDR  = {REG_STOP, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     frame_type;
    logic [ADDR_W-1:0]     frame_addr;
    logic [CNT_W-1:0]      payload_count;
    logic [BYTE_W-1:0]     data_byte;
    logic                  data_valid;
    logic                  last;

    int                    mismatches;
    int                    results_due;

    // stimulus side copy of the codes, only to build frames
    logic [BYTE_W-1:0]     cur_start;
    logic [BYTE_W-1:0]     cur_stop;
    int                    bytes_sent;
    int                    in_gap_max;
    int                    out_gap_max;
    logic                  hold_req;
    logic [BYTE_W-1:0]     directed_seq [25];

    serial_frame_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_type    (frame_type),
        .frame_addr    (frame_addr),
        .payload_count (payload_count),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .last          (last)
    );

    serial_frame_parser_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_type    (frame_type),
        .frame_addr    (frame_addr),
        .payload_count (payload_count),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .last          (last),
        .mismatches    (mismatches),
        .results_due   (results_due)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case a handshake never completes
    initial
    begin
        #LIMIT_NS;
        $display("== FAIL ==");
        $finish;
    end

    // one received byte as one request; leaves valid high on return so a
    // following byte with no gap goes out back to back
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // start, length, then bytes up to the closing index; lengths whose
    // closing index lies past the store run until the index wraps
    task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] closer);
        int n;
        send_byte(cur_start);
        send_byte(len);
        n = (int'(len) + STOP_OFFSET < FRAME_MAX) ? int'(len) : FRAME_MAX - STOP_OFFSET;
        for (int i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        if (int'(len) + STOP_OFFSET < FRAME_MAX)
            send_byte(closer);
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // setup cycle, then access cycle; upper data bits carry junk
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = ($urandom() & 32'hFFFF_FF00) | APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] start_v, input logic [BYTE_W-1:0] stop_v);
        write_reg(START_ADDR, start_v);
        write_reg(STOP_ADDR, stop_v);
        cur_start = start_v;
        cur_stop  = stop_v;
    endtask

    // mostly good frames with random content, the rest broken frames,
    // overruns and noise; pacing switches between bursts and gaps
    task automatic random_stream(input int budget);
        int                target;
        int                pick;
        int                noise_len;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] b;
        target = bytes_sent + budget;
        while (bytes_sent < target)
        begin
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // good frame, now and then one of the longest
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(0, 1) ? 8'd61 : BYTE_W'($urandom_range(40, 60));
                else
                    len = BYTE_W'($urandom_range(HEADER_EXTRA, 12));
                send_frame(len, cur_stop);
            end
            else if (pick < 77)
            begin
                // wrong closing byte
                do
                    b = BYTE_W'($urandom_range(0, 255));
                while (b == cur_stop);
                send_frame(BYTE_W'($urandom_range(HEADER_EXTRA, 12)), b);
            end
            else if (pick < 85)
            begin
                // length below three, closed either way
                b = $urandom_range(0, 1) ? cur_stop : BYTE_W'($urandom_range(0, 255));
                send_frame(BYTE_W'($urandom_range(0, HEADER_EXTRA - 1)), b);
            end
            else if (pick < 88)
            begin
                // closing index beyond the store, index wraps
                send_frame(BYTE_W'($urandom_range(FRAME_MAX - STOP_OFFSET, 255)), cur_stop);
            end
            else
            begin
                // line noise between frames
                noise_len = $urandom_range(1, 4);
                for (int i = 0; i < noise_len; i++)
                begin
                    do
                        b = BYTE_W'($urandom_range(0, 255));
                    while (b == cur_start);
                    send_byte(b);
                end
            end
        end
    endtask

    // result side: random stall per result, plus a long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        rst_n       = 1'b0;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        in_gap_max  = GAP_MAX;
        out_gap_max = GAP_MAX;
        cur_start   = START_RESET;
        cur_stop    = STOP_RESET;

        // empty payload with all header bits set; two payload bytes with
        // zero header and both payload extremes; a bad stop that equals the
        // start byte; a length below three closed by a good stop byte
        directed_seq = '{
            START_RESET, 8'h03, 8'hFF, 8'hFF, 8'hFF, STOP_RESET,
            START_RESET, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, STOP_RESET,
            START_RESET, 8'h03, 8'h12, 8'h34, 8'h56, START_RESET,
            START_RESET, 8'h02, 8'h00, 8'h00, STOP_RESET
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset codes
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);
        random_stream(PHASE_BYTES);

        // receiver holds off while the sender keeps pushing frames, so the
        // drain backs up and the input stalls
        in_gap_max  = 0;
        out_gap_max = 0;
        hold_req    = 1'b1;
        for (int i = 0; i < 3; i++)
            send_frame(BYTE_W'($urandom_range(8, 12)), cur_stop);
        wait_drained();

        // codes at the extremes, then swapped, then random
        set_codes(8'h00, 8'hFF);
        random_stream(PHASE_BYTES);
        wait_drained();

        set_codes(8'hFF, 8'h00);
        random_stream(PHASE_BYTES);
        wait_drained();

        set_codes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        random_stream(PHASE_BYTES);
        wait_drained();

        // let anything still in flight show up before the verdict
        repeat (20) @(negedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
